// ===== rtl/asc_pkg.sv =====
// Shared types and constants for the aliquot sum classifier.
// No dependencies; every other file refers to this package by scoped names.
package asc_pkg;

  // Width of the result fields that do not follow the number width.
  localparam int PDS_WIDTH   = 35;
  localparam int COUNT_WIDTH = 32;

  // Extra bits of the divisor sum over the number width (sigma(n) < 8n here).
  localparam int SUM_MARGIN = 3;

  // Trial divisor sequence: 2, 3, 5, then alternating steps of 2 and 4.
  localparam int CAND_FIRST  = 2;
  localparam int CAND_SECOND = 3;
  localparam int CAND_THIRD  = 5;
  localparam int STEP_SHORT  = 2;
  localparam int STEP_LONG   = 4;

  // Operation of the shared shift/add unit.
  typedef enum logic {
    OP_DIV,
    OP_MUL
  } arith_op_t;

  // Command from the sequencer to the shared unit.
  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DIV,
    SQ_MUL_GEO,
    SQ_MUL_PROD,
    SQ_MUL_LAST,
    SQ_REPORT
  } seq_state_t;

  // Classification codes.
  typedef enum logic [1:0] {
    KIND_DEFICIENT = 2'd0,
    KIND_PERFECT   = 2'd1,
    KIND_ABUNDANT  = 2'd2
  } kind_t;

endpackage

// ===== rtl/asc_arith_unit.sv =====
// Shared bit-serial arithmetic unit: restoring division and shift-add multiply.
// Both operations run through one adder, one bit per cycle. Uses asc_pkg.
module asc_arith_unit #(
  parameter int DATA_WIDTH = 35
) (
  input  logic                    clk,
  input  logic                    rst,
  input  asc_pkg::arith_cmd_t     cmd,
  input  logic [DATA_WIDTH-1:0]   opnd_a,
  input  logic [DATA_WIDTH-1:0]   opnd_b,
  output logic                    busy,
  output logic                    done,
  output logic [DATA_WIDTH-1:0]   acc_out,
  output logic [DATA_WIDTH-1:0]   shift_out
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] shreg;
  logic [DATA_WIDTH-1:0] divisor;
  logic [CW-1:0]         cnt;
  asc_pkg::arith_op_t    op;

  logic [DATA_WIDTH+1:0] add_a;
  logic [DATA_WIDTH+1:0] add_b;
  logic                  sub;
  logic [DATA_WIDTH+1:0] sum;
  logic                  borrow;
  logic [DATA_WIDTH-1:0] acc_next;
  logic [DATA_WIDTH-1:0] shreg_next;

  // Operand selection for the single shared adder.
  always_comb begin
    unique case (op)
      asc_pkg::OP_DIV: begin
        add_a = {1'b0, acc, shreg[DATA_WIDTH-1]};
        add_b = {2'b00, divisor};
        sub   = 1'b1;
      end
      asc_pkg::OP_MUL: begin
        add_a = {2'b00, acc[DATA_WIDTH-2:0], 1'b0};
        add_b = shreg[DATA_WIDTH-1] ? {2'b00, divisor} : '0;
        sub   = 1'b0;
      end
    endcase
  end

  // The adder, plus the restore decision for division.
  always_comb begin
    sum    = add_a + (sub ? ~add_b : add_b) + {{(DATA_WIDTH+1){1'b0}}, sub};
    borrow = sum[DATA_WIDTH+1];
    if ((op == asc_pkg::OP_DIV) && borrow) begin
      acc_next = add_a[DATA_WIDTH-1:0];
    end else begin
      acc_next = sum[DATA_WIDTH-1:0];
    end
    shreg_next = {shreg[DATA_WIDTH-2:0], (op == asc_pkg::OP_DIV) & ~borrow};
  end

  // Control: bit counter, busy and the completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= asc_pkg::OP_DIV;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_WIDTH);
        op   <= cmd.op;
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers: remainder or product, and quotient or multiplier bits.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc     <= '0;
      shreg   <= opnd_a;
      divisor <= opnd_b;
    end else if (busy) begin
      acc   <= acc_next;
      shreg <= shreg_next;
    end
  end

  assign acc_out   = acc;
  assign shift_out = shreg;

endmodule

// ===== rtl/asc_sequencer.sv =====
// Trial-division sequencer: walks candidates 2, 3, 6k-1, 6k+1 and builds the
// divisor sum with the shared unit in asc_arith_unit. Uses asc_pkg.
module asc_sequencer #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [NUMBER_WIDTH-1:0]                       number,
  input  logic                                          number_valid,
  output logic                                          number_ready,
  output logic                                          sigma_valid,
  input  logic                                          sigma_ready,
  output logic [NUMBER_WIDTH+asc_pkg::SUM_MARGIN-1:0]   sigma,
  output logic [NUMBER_WIDTH-1:0]                       number_held,
  output logic                                          number_zero
);

  localparam int SW = NUMBER_WIDTH + asc_pkg::SUM_MARGIN;
  localparam int W  = NUMBER_WIDTH;

  asc_pkg::seq_state_t state;
  asc_pkg::seq_state_t state_next;

  logic [W-1:0]  rest;
  logic [W-1:0]  cand;
  logic          step_two;
  logic          head;
  logic [SW-1:0] geo;
  logic [SW-1:0] prod;

  logic [W-1:0]  cand_next;
  logic          step_two_next;
  logic [SW-1:0] cand_ext;
  logic [SW-1:0] cand_next_ext;
  logic [SW-1:0] rest_ext;
  logic          div_stop;
  logic          rem_zero;
  logic          geo_one;
  logic          rest_big;

  asc_pkg::arith_cmd_t cmd;
  logic [SW-1:0]       opnd_a;
  logic [SW-1:0]       opnd_b;
  logic                arith_busy;
  logic                arith_done;
  logic [SW-1:0]       arith_acc;
  logic [SW-1:0]       arith_shift;

  asc_arith_unit #(
    .DATA_WIDTH(SW)
  ) u_arith (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .opnd_a   (opnd_a),
    .opnd_b   (opnd_b),
    .busy     (arith_busy),
    .done     (arith_done),
    .acc_out  (arith_acc),
    .shift_out(arith_shift)
  );

  // Next trial divisor: 2, 3, 5, then +2 and +4 in turn.
  always_comb begin
    if (cand == W'(asc_pkg::CAND_FIRST)) begin
      cand_next     = W'(asc_pkg::CAND_SECOND);
      step_two_next = 1'b0;
    end else if (cand == W'(asc_pkg::CAND_SECOND)) begin
      cand_next     = W'(asc_pkg::CAND_THIRD);
      step_two_next = 1'b1;
    end else if (step_two) begin
      cand_next     = cand + W'(asc_pkg::STEP_SHORT);
      step_two_next = 1'b0;
    end else begin
      cand_next     = cand + W'(asc_pkg::STEP_LONG);
      step_two_next = 1'b1;
    end
  end

  // Decisions taken on a finished division.
  always_comb begin
    cand_ext      = {{(SW-W){1'b0}}, cand};
    cand_next_ext = {{(SW-W){1'b0}}, cand_next};
    rest_ext      = {{(SW-W){1'b0}}, rest};
    div_stop      = head && (arith_shift < cand_ext);
    rem_zero      = (arith_acc == '0);
    geo_one       = (geo == SW'(1));
    rest_big      = (rest > W'(1));
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      asc_pkg::SQ_IDLE: begin
        if (number_valid) begin
          state_next = asc_pkg::SQ_DIV;
        end
      end
      asc_pkg::SQ_DIV: begin
        if (arith_done) begin
          if (div_stop) begin
            state_next = rest_big ? asc_pkg::SQ_MUL_LAST : asc_pkg::SQ_REPORT;
          end else if (rem_zero) begin
            state_next = asc_pkg::SQ_MUL_GEO;
          end else if (!geo_one) begin
            state_next = asc_pkg::SQ_MUL_PROD;
          end
        end
      end
      asc_pkg::SQ_MUL_GEO: begin
        if (arith_done) begin
          state_next = asc_pkg::SQ_DIV;
        end
      end
      asc_pkg::SQ_MUL_PROD: begin
        if (arith_done) begin
          state_next = asc_pkg::SQ_DIV;
        end
      end
      asc_pkg::SQ_MUL_LAST: begin
        if (arith_done) begin
          state_next = asc_pkg::SQ_REPORT;
        end
      end
      asc_pkg::SQ_REPORT: begin
        if (sigma_ready) begin
          state_next = asc_pkg::SQ_IDLE;
        end
      end
      default: state_next = asc_pkg::SQ_IDLE;
    endcase
  end

  // Outputs: handshakes and the command to the shared unit.
  always_comb begin
    number_ready = (state == asc_pkg::SQ_IDLE);
    sigma_valid  = (state == asc_pkg::SQ_REPORT);
    cmd.start    = 1'b0;
    cmd.op       = asc_pkg::OP_DIV;
    opnd_a       = '0;
    opnd_b       = '0;
    unique case (state)
      asc_pkg::SQ_IDLE: begin
        if (number_valid) begin
          cmd.start = 1'b1;
          opnd_a    = {{(SW-W){1'b0}}, number};
          opnd_b    = SW'(asc_pkg::CAND_FIRST);
        end
      end
      asc_pkg::SQ_DIV: begin
        if (arith_done) begin
          if (div_stop) begin
            if (rest_big) begin
              cmd.start = 1'b1;
              cmd.op    = asc_pkg::OP_MUL;
              opnd_a    = prod;
              opnd_b    = rest_ext + SW'(1);
            end
          end else if (rem_zero) begin
            cmd.start = 1'b1;
            cmd.op    = asc_pkg::OP_MUL;
            opnd_a    = cand_ext;
            opnd_b    = geo;
          end else if (!geo_one) begin
            cmd.start = 1'b1;
            cmd.op    = asc_pkg::OP_MUL;
            opnd_a    = prod;
            opnd_b    = geo;
          end else begin
            cmd.start = 1'b1;
            opnd_a    = rest_ext;
            opnd_b    = cand_next_ext;
          end
        end
      end
      asc_pkg::SQ_MUL_GEO: begin
        if (arith_done) begin
          cmd.start = 1'b1;
          opnd_a    = rest_ext;
          opnd_b    = cand_ext;
        end
      end
      asc_pkg::SQ_MUL_PROD: begin
        if (arith_done) begin
          cmd.start = 1'b1;
          opnd_a    = rest_ext;
          opnd_b    = cand_next_ext;
        end
      end
      asc_pkg::SQ_MUL_LAST: begin
      end
      asc_pkg::SQ_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asc_pkg::SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Factorization registers: cofactor, candidate, geometric and running sums.
  always_ff @(posedge clk) begin
    unique case (state)
      asc_pkg::SQ_IDLE: begin
        if (number_valid) begin
          number_held <= number;
          number_zero <= (number == '0);
          rest        <= number;
          cand        <= W'(asc_pkg::CAND_FIRST);
          step_two    <= 1'b0;
          head        <= 1'b1;
          geo         <= SW'(1);
          prod        <= SW'(1);
        end
      end
      asc_pkg::SQ_DIV: begin
        if (arith_done && !div_stop) begin
          if (rem_zero) begin
            rest <= arith_shift[W-1:0];
          end else if (geo_one) begin
            cand     <= cand_next;
            step_two <= step_two_next;
            head     <= 1'b1;
          end
        end
      end
      asc_pkg::SQ_MUL_GEO: begin
        if (arith_done) begin
          geo  <= arith_acc + SW'(1);
          head <= 1'b0;
        end
      end
      asc_pkg::SQ_MUL_PROD: begin
        if (arith_done) begin
          prod     <= arith_acc;
          geo      <= SW'(1);
          cand     <= cand_next;
          step_two <= step_two_next;
          head     <= 1'b1;
        end
      end
      asc_pkg::SQ_MUL_LAST: begin
        if (arith_done) begin
          prod <= arith_acc;
        end
      end
      asc_pkg::SQ_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  assign sigma = prod;

  // The shared unit is only started when it has finished its last operation.
  assert property (@(posedge clk) disable iff (rst) cmd.start |-> !arith_busy)
    else $error("shared unit started while busy");

  // Trial divisors never drop below two while an item is in progress.
  assert property (@(posedge clk) disable iff (rst)
    (state != asc_pkg::SQ_IDLE) |-> (cand >= W'(asc_pkg::CAND_FIRST)))
    else $error("trial divisor below two");

  // The divisor sum handed on is never zero.
  assert property (@(posedge clk) disable iff (rst) sigma_valid |-> (prod != '0))
    else $error("divisor sum is zero");

endmodule

// ===== rtl/aliquot_sum_classifier_core.sv =====
// Top level of the aliquot sum classifier: trial-division sequencer, output
// register, classification and saturating counters. Uses asc_pkg, asc_sequencer.
//
// Each number is factored by trial division with one shared bit-serial
// shift/add unit, so the block takes one transaction at a time and holds
// number_ready low until the divisor sum is handed to the output register.
// An item costs roughly (trial divisors tried + one extra division per prime
// factor found) divisions plus one multiplication per prime factor found and
// one more per distinct prime, and the trial divisors run up to the square
// root of the remaining cofactor, about sqrt(n)/3 of them. The finished
// result waits in an output register, and the next number can be taken while
// it waits. Counts of deficient and abundant numbers saturate at all ones;
// zero is reported as deficient with a sum of zero and not counted.
module aliquot_sum_classifier_core #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [NUMBER_WIDTH-1:0]           number,
  input  logic                              number_valid,
  output logic                              number_ready,
  output logic [asc_pkg::PDS_WIDTH-1:0]     proper_divisor_sum,
  output logic [1:0]                        kind,
  output logic [asc_pkg::COUNT_WIDTH-1:0]   deficient_total,
  output logic [asc_pkg::COUNT_WIDTH-1:0]   abundant_total,
  output logic                              result_valid,
  input  logic                              result_ready
);

  localparam int W  = NUMBER_WIDTH;
  localparam int SW = NUMBER_WIDTH + asc_pkg::SUM_MARGIN;
  localparam int PW = asc_pkg::PDS_WIDTH;
  localparam int CW = asc_pkg::COUNT_WIDTH;

  logic          sigma_valid;
  logic          sigma_ready;
  logic [SW-1:0] sigma;
  logic [W-1:0]  number_held;
  logic          number_zero;
  logic          sigma_fire;

  logic [SW-1:0]      twice_n;
  logic [SW-1:0]      proper;
  logic [SW+PW-1:0]   proper_ext;
  logic [PW-1:0]      pds_value;
  asc_pkg::kind_t     kind_value;
  asc_pkg::kind_t     result_kind;
  logic [CW-1:0]      deficient_count;
  logic [CW-1:0]      abundant_count;

  asc_sequencer #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .number      (number),
    .number_valid(number_valid),
    .number_ready(number_ready),
    .sigma_valid (sigma_valid),
    .sigma_ready (sigma_ready),
    .sigma       (sigma),
    .number_held (number_held),
    .number_zero (number_zero)
  );

  // The output register takes a new result when empty or being drained.
  assign sigma_ready = !result_valid || result_ready;
  assign sigma_fire  = sigma_valid && sigma_ready;

  // Proper sum and classification: compare sigma against twice the number.
  always_comb begin
    twice_n    = {{(SW-W-1){1'b0}}, number_held, 1'b0};
    proper     = sigma - {{(SW-W){1'b0}}, number_held};
    proper_ext = {{PW{1'b0}}, proper};
    pds_value  = number_zero ? '0 : proper_ext[PW-1:0];
    if (number_zero) begin
      kind_value = asc_pkg::KIND_DEFICIENT;
    end else if (sigma == twice_n) begin
      kind_value = asc_pkg::KIND_PERFECT;
    end else if (sigma < twice_n) begin
      kind_value = asc_pkg::KIND_DEFICIENT;
    end else begin
      kind_value = asc_pkg::KIND_ABUNDANT;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (sigma_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (sigma_fire) begin
      proper_divisor_sum <= pds_value;
      result_kind        <= kind_value;
    end
  end

  // Saturating counters, updated with each loaded result of a nonzero number.
  always_ff @(posedge clk) begin
    if (rst) begin
      deficient_count <= '0;
      abundant_count  <= '0;
    end else if (sigma_fire && !number_zero) begin
      if ((kind_value == asc_pkg::KIND_DEFICIENT) && (deficient_count != '1)) begin
        deficient_count <= deficient_count + CW'(1);
      end
      if ((kind_value == asc_pkg::KIND_ABUNDANT) && (abundant_count != '1)) begin
        abundant_count <= abundant_count + CW'(1);
      end
    end
  end

  assign kind            = result_kind;
  assign deficient_total = deficient_count;
  assign abundant_total  = abundant_count;

  // The counters only ever move upward.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (deficient_count >= $past(deficient_count)) &&
                    (abundant_count >= $past(abundant_count)))
    else $error("counter decreased");

  // A perfect number leaves both counters as they were.
  assert property (@(posedge clk) disable iff (rst)
    (sigma_fire && (kind_value == asc_pkg::KIND_PERFECT)) |=>
      $stable(deficient_count) && $stable(abundant_count))
    else $error("perfect number changed a counter");

  // An abundant result implies a nonzero abundant count.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_kind == asc_pkg::KIND_ABUNDANT)) |-> (abundant_count != '0))
    else $error("abundant result without count");

endmodule

// ===== test/tb_aliquot_sum_classifier_core.sv =====
// Self-checking testbench for aliquot_sum_classifier_core.
// Depends on asc_pkg and the core; it predicts every result with its own divisor-sum
// calculation and checks the results in order under random sender gaps and sink stalls.
module tb_aliquot_sum_classifier_core;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 200000;
  // Highest trial-divisor count allowed for a random number, to keep the run short.
  localparam int TRIAL_CAP = 300;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_EVERY = 25;
  localparam int SETTLE_CYCLES = 50;
  localparam logic [31:0] COUNT_FULL = 32'hFFFF_FFFF;

  typedef enum {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE
  } sink_mode_t;

  typedef struct {
    logic [31:0]      number;
    logic [34:0]      proper_sum;
    asc_pkg::kind_t   kind;
    logic [31:0]      deficient_count;
    logic [31:0]      abundant_count;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst;
  logic [31:0] number;
  logic        number_valid;
  logic        number_ready;
  logic [34:0] proper_divisor_sum;
  logic [1:0]  kind;
  logic [31:0] deficient_total;
  logic [31:0] abundant_total;
  logic        result_valid;
  logic        result_ready;

  // Expected results, oldest first, and the predicted running counts.
  verdict_t    pending_verdicts[$];
  logic [31:0] deficient_seen = '0;
  logic [31:0] abundant_seen = '0;
  int          perfect_seen = 0;
  int          zero_seen = 0;
  int          numbers_sent = 0;
  int          mismatches = 0;
  int          burst_left = 0;

  int unsigned smooth_primes [8] = '{2, 3, 5, 7, 11, 13, 17, 31};

  always #6 clk = ~clk;

  aliquot_sum_classifier_core u_dut (
    .clk                (clk),
    .rst                (rst),
    .number             (number),
    .number_valid       (number_valid),
    .number_ready       (number_ready),
    .proper_divisor_sum (proper_divisor_sum),
    .kind               (kind),
    .deficient_total    (deficient_total),
    .abundant_total     (abundant_total),
    .result_valid       (result_valid),
    .result_ready       (result_ready)
  );

  // Sum of all divisors of n by trial division over 2, 3 and then 6k-1, 6k+1.
  // Also returns how many trial divisors were tried, a measure of the block's run time.
  function automatic longint unsigned divisor_total(input longint unsigned n,
                                                    output int trials);
    longint unsigned rest;
    longint unsigned total;
    longint unsigned p;
    longint unsigned term;
    rest = n;
    total = 1;
    p = 2;
    trials = 0;
    while (p * p <= rest) begin
      term = 1;
      while (rest % p == 0) begin
        term = term * p + 1;
        rest = rest / p;
      end
      total = total * term;
      trials++;
      if (p == 2) begin
        p = 3;
      end else if (p == 3) begin
        p = 5;
      end else if (p % 6 == 5) begin
        p = p + 2;
      end else begin
        p = p + 4;
      end
    end
    if (rest > 1) begin
      total = total * (rest + 1);
    end
    return total;
  endfunction

  // Classify one accepted number, update the predicted counts and queue the expected result.
  task automatic predict_verdict(input logic [31:0] n);
    verdict_t        v;
    longint unsigned sigma;
    longint unsigned proper;
    int              trials;
    v.number = n;
    v.kind = asc_pkg::KIND_DEFICIENT;
    proper = 0;
    if (n == 0) begin
      zero_seen++;
    end else begin
      sigma = divisor_total(n, trials);
      proper = sigma - n;
      if (proper == n) begin
        v.kind = asc_pkg::KIND_PERFECT;
        perfect_seen++;
      end else if (proper < n) begin
        if (deficient_seen != COUNT_FULL) begin
          deficient_seen++;
        end
      end else begin
        v.kind = asc_pkg::KIND_ABUNDANT;
        if (abundant_seen != COUNT_FULL) begin
          abundant_seen++;
        end
      end
    end
    v.proper_sum = proper[34:0];
    v.deficient_count = deficient_seen;
    v.abundant_count = abundant_seen;
    pending_verdicts.push_back(v);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] n,
                                 input longint unsigned got, input longint unsigned want);
    $display("MISMATCH %s for number %0d: got %0d, expected %0d", what, n, got, want);
    mismatches++;
  endtask

  // Send one number. The sender works in bursts; between bursts it usually drops valid for a
  // random gap. Within a burst valid stays high from one transaction to the next.
  task automatic send_number(input logic [31:0] n);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        number_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    number = n;
    number_valid = 1'b1;
    @(posedge clk);
    while (!number_ready) @(posedge clk);
    predict_verdict(n);
    numbers_sent++;
    burst_left--;
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    number_valid = 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Random number whose trial division stays short: raw 32-bit values, small values,
  // and products of small primes with a modest cofactor.
  function automatic logic [31:0] random_number();
    logic [31:0]     pick;
    longint unsigned v;
    longint unsigned unused;
    int unsigned     p;
    int              trials;
    for (int tries = 0; tries < 400; tries++) begin
      case ($urandom_range(0, 3))
        0: pick = $urandom;
        1: pick = $urandom_range(0, 5000);
        default: begin
          v = $urandom_range(1, 1 << 18);
          repeat ($urandom_range(0, 14)) begin
            p = smooth_primes[$urandom_range(0, 7)];
            if (v * p <= 64'hFFFF_FFFF) begin
              v = v * p;
            end
          end
          pick = v[31:0];
        end
      endcase
      unused = divisor_total(pick, trials);
      if (trials <= TRIAL_CAP) begin
        return pick;
      end
    end
    return 32'd720720;
  endfunction

  // Zero, one, small primes and prime powers, a clear abundant case.
  task automatic test_special_values();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd2);
    send_number(32'd3);
    send_number(32'd4);
    send_number(32'd12);
    send_number(32'd25);
    send_number(32'd65521);
    send_number(32'd0);
  endtask

  // Every perfect number that fits in 32 bits and factors quickly.
  task automatic test_perfect_numbers();
    send_number(32'd6);
    send_number(32'd28);
    send_number(32'd496);
    send_number(32'd8128);
    send_number(32'd33550336);
  endtask

  // Top of the range, single high bit, alternating bit patterns and large smooth numbers.
  task automatic test_field_extremes();
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'hAAAA_AAAA);
    send_number(32'h5555_5555);
    send_number(32'hFFFF_0000);
    send_number(32'd3486784401);
    send_number(32'd735134400);
  endtask

  // Random numbers, with the sender held off until the block is drained now and then.
  task automatic test_random_numbers();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_number(random_number());
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
        drain_results();
      end
    end
  endtask

  // Result sink: stalls on a pattern whose mode changes when a random age counter runs out.
  initial begin : result_sink
    sink_mode_t mode;
    int         age;
    result_ready = 1'b0;
    mode = SINK_OPEN;
    age = 0;
    forever begin
      @(negedge clk);
      if (age == 0) begin
        mode = sink_mode_t'($urandom_range(0, 2));
        age = $urandom_range(20, 120);
      end
      age--;
      case (mode)
        SINK_OPEN:   result_ready = 1'b1;
        SINK_COIN:   result_ready = $urandom_range(0, 1);
        SINK_SPARSE: result_ready = (age % 6 == 0);
        default:     result_ready = 1'b1;
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing pending, sum", 32'd0, proper_divisor_sum, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (proper_divisor_sum !== want.proper_sum) begin
          report_mismatch("proper_divisor_sum", want.number, proper_divisor_sum,
                          want.proper_sum);
        end
        if (kind !== want.kind) begin
          report_mismatch("kind", want.number, kind, want.kind);
        end
        if (deficient_total !== want.deficient_count) begin
          report_mismatch("deficient_total", want.number, deficient_total,
                          want.deficient_count);
        end
        if (abundant_total !== want.abundant_count) begin
          report_mismatch("abundant_total", want.number, abundant_total,
                          want.abundant_count);
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction completes for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((number_valid && number_ready) || (result_valid && result_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timed out after %0d cycles with no transaction", STALL_LIMIT);
    $display("aliquot_sum_classifier_core test failed");
    $finish;
  end

  // Test sequence.
  initial begin : main_sequence
    rst = 1'b1;
    number = '0;
    number_valid = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_special_values();
    test_perfect_numbers();
    test_field_extremes();
    drain_results();
    test_random_numbers();

    // Let the last results come back, then wait out SETTLE_CYCLES to catch stray output.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d numbers: %0d deficient, %0d perfect, %0d abundant, %0d zero.",
             numbers_sent, deficient_seen, perfect_seen, abundant_seen, zero_seen);
    $display("Field extremes, sender bursts and pauses, and sink stalls were exercised.");
    if (mismatches == 0) begin
      $display("aliquot_sum_classifier_core test passed");
    end else begin
      $display("aliquot_sum_classifier_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/asc_pkg.sv
rtl/asc_arith_unit.sv
rtl/asc_sequencer.sv
rtl/aliquot_sum_classifier_core.sv
test/tb_aliquot_sum_classifier_core.sv
